// ===== design/array_list_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Array list engine assertion macros
// Shared property wrappers, clocked on i_clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ARRAY_LIST_ENGINE_DEFINES_SVH
`define ARRAY_LIST_ENGINE_DEFINES_SVH

// same-cycle implication
`define ALE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ALE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ale_pkg.sv =====
// ----------------------------------------------------------------------------
// Array list engine package
// Request and response words, operation and status codes, controller types.
// ----------------------------------------------------------------------------
package ale_pkg;

    typedef enum logic [2:0] {
        F_APPEND = 3'd0,
        F_POP    = 3'd1,
        F_READ   = 3'd2,
        F_FIND   = 3'd3,
        F_INSERT = 3'd4,
        F_DELETE = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] value;
        logic [6:0]  position;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] data;
        logic [5:0]  found_at;
        logic [6:0]  fill_count;
        logic        is_empty;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_WALK,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic exec;
        logic rd_cap;
        logic walk;
        logic fin;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic exec_walk;
        logic exec_read;
        logic walk_done;
        logic ins_fin;
        logic out_free;
    } t_sts;

endpackage

// ===== design/ale_stream_if.sv =====
// ----------------------------------------------------------------------------
// Array list engine stream interface
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface ale_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/ale_ctrl.sv =====
// ----------------------------------------------------------------------------
// Array list engine controller
// Sequences decode, store read, walk, final insert write and result handoff.
// ----------------------------------------------------------------------------
module ale_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  ale_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output ale_pkg::t_cmd o_cmd
);

    ale_pkg::t_state r_state;
    ale_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ale_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ale_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = ale_pkg::S_EXEC;
                end
            end
            ale_pkg::S_EXEC: begin
                if (i_sts.exec_walk) begin
                    n_state = ale_pkg::S_WALK;
                end else if (i_sts.exec_read) begin
                    n_state = ale_pkg::S_RDWAIT;
                end else begin
                    n_state = ale_pkg::S_DONE;
                end
            end
            ale_pkg::S_RDWAIT: begin
                n_state = ale_pkg::S_DONE;
            end
            ale_pkg::S_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = i_sts.ins_fin ? ale_pkg::S_FIN : ale_pkg::S_DONE;
                end
            end
            ale_pkg::S_FIN: begin
                n_state = ale_pkg::S_DONE;
            end
            ale_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ale_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ale_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ale_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ale_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            ale_pkg::S_RDWAIT: begin
                o_cmd.rd_cap = 1'b1;
            end
            ale_pkg::S_WALK: begin
                o_cmd.walk = 1'b1;
            end
            ale_pkg::S_FIN: begin
                o_cmd.fin = 1'b1;
            end
            ale_pkg::S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== design/ale_dpath.sv =====
// ----------------------------------------------------------------------------
// Array list engine datapath
// Entry store, fill count, walk pointer and result/output registers.
// ----------------------------------------------------------------------------
module ale_dpath #(
    parameter int CAPACITY      = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ale_pkg::t_cmd i_cmd,
    input  ale_pkg::t_req i_req,
    input  logic          i_out_ready,
    output ale_pkg::t_sts o_sts,
    output logic          o_out_valid,
    output ale_pkg::t_rsp o_out
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = (CW > 7) ? CW : 7;
    localparam int EW = ELEMENT_WIDTH;

    logic [EW-1:0] mem [CAPACITY];

    logic [CW-1:0]  r_count, n_count;
    logic [2:0]     r_func, n_func;
    logic [EW-1:0]  r_val, n_val;
    logic [6:0]     r_pos, n_pos;
    logic [AW-1:0]  r_idx, n_idx;
    logic [CW-1:0]  r_left, n_left;
    logic           r_pend, n_pend;
    logic [AW-1:0]  r_pidx, n_pidx;
    logic [EW-1:0]  r_rdata;
    ale_pkg::t_rsp  r_res, n_res;
    ale_pkg::t_rsp  r_out;
    logic           r_out_valid;

    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    logic [EW-1:0]  mem_wd;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;

    logic [XW-1:0]  pos_x;
    logic [XW-1:0]  cnt_x;
    logic           full;
    logic           bad_rd;
    logic           bad_ins;
    logic           step;
    logic           match;
    logic           walk_done;
    logic           out_free;

    assign pos_x     = XW'(r_pos);
    assign cnt_x     = XW'(r_count);
    assign full      = (r_count == CW'(CAPACITY));
    assign bad_rd    = (pos_x >= cnt_x);
    assign bad_ins   = (pos_x > cnt_x);
    assign step      = (r_left != '0);
    assign match     = r_pend && (r_rdata == r_val);
    assign walk_done = ((r_func == ale_pkg::F_FIND) && match) || (!step && !r_pend);
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts.exec_walk = 1'b0;
        o_sts.exec_read = 1'b0;
        case (r_func)
            ale_pkg::F_READ:   o_sts.exec_read = !bad_rd;
            ale_pkg::F_FIND:   o_sts.exec_walk = 1'b1;
            ale_pkg::F_INSERT: o_sts.exec_walk = !full && !bad_ins;
            ale_pkg::F_DELETE: o_sts.exec_walk = !bad_rd;
            default: begin
                o_sts.exec_walk = 1'b0;
                o_sts.exec_read = 1'b0;
            end
        endcase
        o_sts.walk_done = walk_done;
        o_sts.ins_fin   = (r_func == ale_pkg::F_INSERT);
        o_sts.out_free  = out_free;
    end

    always_comb begin
        n_count = r_count;
        n_func  = r_func;
        n_val   = r_val;
        n_pos   = r_pos;
        n_idx   = r_idx;
        n_left  = r_left;
        n_pend  = r_pend;
        n_pidx  = r_pidx;
        n_res   = r_res;
        mem_we  = 1'b0;
        mem_wa  = '0;
        mem_wd  = r_val;
        rd_en   = 1'b0;
        rd_addr = '0;

        if (i_cmd.accept) begin
            n_func = i_req.func;
            n_val  = EW'(i_req.value);
            n_pos  = i_req.position;
        end

        if (i_cmd.exec) begin
            n_res        = '0;
            n_res.status = ale_pkg::ST_OK;
            n_pend       = 1'b0;
            n_left       = '0;
            case (r_func)
                ale_pkg::F_APPEND: begin
                    if (full) begin
                        n_res.status = ale_pkg::ST_FULL;
                    end else begin
                        mem_we  = 1'b1;
                        mem_wa  = r_count[AW-1:0];
                        n_count = r_count + CW'(1);
                    end
                end
                ale_pkg::F_POP: begin
                    if (r_count == '0) begin
                        n_res.status = ale_pkg::ST_EMPTY;
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end
                ale_pkg::F_READ: begin
                    if (bad_rd) begin
                        n_res.status = ale_pkg::ST_BADPOS;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = pos_x[AW-1:0];
                    end
                end
                ale_pkg::F_FIND: begin
                    n_idx  = '0;
                    n_left = r_count;
                end
                ale_pkg::F_INSERT: begin
                    if (full) begin
                        n_res.status = ale_pkg::ST_FULL;
                    end else if (bad_ins) begin
                        n_res.status = ale_pkg::ST_BADPOS;
                    end else begin
                        n_idx  = AW'(r_count - CW'(1));
                        n_left = CW'(cnt_x - pos_x);
                    end
                end
                ale_pkg::F_DELETE: begin
                    if (bad_rd) begin
                        n_res.status = ale_pkg::ST_BADPOS;
                    end else begin
                        n_idx  = AW'(pos_x + XW'(1));
                        n_left = CW'(cnt_x - pos_x - XW'(1));
                    end
                end
                default: begin
                    n_res.status = ale_pkg::ST_OK;
                end
            endcase
        end

        if (i_cmd.rd_cap) begin
            n_res.data = 32'(r_rdata);
        end

        if (i_cmd.walk) begin
            n_pend = step;
            n_pidx = r_idx;
            if (step) begin
                rd_en   = 1'b1;
                rd_addr = r_idx;
                n_left  = r_left - CW'(1);
                n_idx   = (r_func == ale_pkg::F_INSERT) ? r_idx - AW'(1) : r_idx + AW'(1);
            end
            if (r_pend && (r_func == ale_pkg::F_INSERT)) begin
                mem_we = 1'b1;
                mem_wa = r_pidx + AW'(1);
                mem_wd = r_rdata;
            end
            if (r_pend && (r_func == ale_pkg::F_DELETE)) begin
                mem_we = 1'b1;
                mem_wa = r_pidx - AW'(1);
                mem_wd = r_rdata;
            end
            if (walk_done && (r_func == ale_pkg::F_FIND)) begin
                n_res.status   = match ? ale_pkg::ST_OK : ale_pkg::ST_NOTFOUND;
                n_res.found_at = match ? 6'(r_pidx) : 6'd0;
            end
            if (walk_done && (r_func == ale_pkg::F_DELETE)) begin
                n_count = r_count - CW'(1);
            end
        end

        if (i_cmd.fin) begin
            mem_we  = 1'b1;
            mem_wa  = pos_x[AW-1:0];
            mem_wd  = r_val;
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_pend  <= n_pend;
            r_left  <= n_left;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_val  <= n_val;
        r_pos  <= n_pos;
        r_idx  <= n_idx;
        r_pidx <= n_pidx;
        r_res  <= n_res;
        if (i_cmd.out_load) begin
            r_out <= {r_res.status, r_res.data, r_res.found_at, 7'(r_count), (r_count == '0)};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== design/array_list_engine.sv =====
// Append, pop and unused codes go from execute straight to the result; read adds a store
// read wait state; find, delete and insert walk the store, a find stopping at its first hit,
// and insert ends with a write of the new word at its position.
// One request at a time: the next is accepted in the cycle after its result is registered.
// The single-port-write store walk sets the request rate.
// Reset (synchronous, active low) clears the fill count and control; entries keep contents.
// ----------------------------------------------------------------------------
// Array list engine top level
// Bounded ordered word list with append, pop, read, find, insert and delete.
// ----------------------------------------------------------------------------
module array_list_engine #(
    parameter int CAPACITY      = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ale_stream_if.sink          i_req,
    ale_stream_if.source        o_rsp
);

    ale_pkg::t_cmd cmd;
    ale_pkg::t_sts sts;
    logic          in_ready;
    logic          out_valid;
    ale_pkg::t_rsp out_word;

    ale_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    ale_dpath #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req.payload),
        .i_out_ready (o_rsp.ready),
        .o_sts       (sts),
        .o_out_valid (out_valid),
        .o_out       (out_word)
    );

    assign i_req.ready   = in_ready;
    assign o_rsp.valid   = out_valid;
    assign o_rsp.payload = out_word;

endmodule

// ===== design/ale_checker.sv =====
// ----------------------------------------------------------------------------
// Array list engine checker
// Port-level properties on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "array_list_engine_defines.svh"

module ale_checker #(
    parameter int CAPACITY = 64
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input ale_pkg::t_rsp i_out_payload
);

    `ALE_ASSERT_NXT(a_rsp_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_payload), "response word changed while stalled")
    `ALE_ASSERT_IMP(a_fill_bound, i_out_valid, i_out_payload.fill_count <= CAPACITY, "fill count beyond capacity")
    `ALE_ASSERT_IMP(a_empty_flag, i_out_valid, i_out_payload.is_empty == (i_out_payload.fill_count == 7'd0), "empty flag disagrees with fill count")
    `ALE_ASSERT_IMP(a_err_no_data, i_out_valid && (i_out_payload.status != ale_pkg::ST_OK), i_out_payload.data == 32'd0, "data on failed request")
    `ALE_ASSERT_IMP(a_miss_no_pos, i_out_valid && (i_out_payload.status != ale_pkg::ST_OK), i_out_payload.found_at == 6'd0, "found position on failed request")

endmodule

bind array_list_engine ale_checker #(
    .CAPACITY (CAPACITY)
) u_ale_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_out_payload (o_rsp.payload)
);

// ===== verif/tb_array_list_engine.sv =====
// ----------------------------------------------------------------------------
// Array list engine testbench
// Runs a directed table of list requests, then random grow, shrink and mixed
// phases, and checks every response word against its table entry or a local list model.
// ----------------------------------------------------------------------------
module tb_array_list_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIST_DEPTH   = 64;
    localparam int          DIR_ROWS     = 30;
    localparam int          RANDOM_ITEMS = 1100;
    localparam int          HOLD_AT      = 600;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 80;
    localparam int          CYCLE_LIMIT  = 700000;
    localparam int          PRINT_CAP    = 50;
    localparam logic [2:0]  FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0]  FUNC_SPARE_7 = 3'd7;

    typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIX} t_mix;
    typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PERIODIC, RX_BURSTY} t_rx_style;

    typedef struct {
        logic [2:0]    func;
        logic [31:0]   value;
        logic [6:0]    position;
        int            reps;
        bit            typed;
        ale_pkg::t_rsp rsp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ale_stream_if #(.t_payload(ale_pkg::t_req)) req_if ();
    ale_stream_if #(.t_payload(ale_pkg::t_rsp)) rsp_if ();

    array_list_engine #(
        .CAPACITY     (LIST_DEPTH),
        .ELEMENT_WIDTH(32)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    logic [31:0]   list_words [LIST_DEPTH];
    int unsigned   list_fill;
    ale_pkg::t_rsp expected_rsp [$];
    t_row          dir_rows [DIR_ROWS];

    int unsigned   mismatches   = 0;
    int unsigned   rsp_seen     = 0;
    int unsigned   req_accepted = 0;
    int unsigned   cycle_count  = 0;
    int unsigned   burst_left   = 0;
    int unsigned   peak_fill    = 0;
    int unsigned   op_tally     [8];
    int unsigned   status_tally [8];
    bit            held_off     = 1'b0;
    t_rx_style     rx_style;
    int unsigned   rx_left      = 0;
    ale_pkg::t_rsp got_rsp;
    ale_pkg::t_rsp want_rsp;

    // list model: applies one request, returns the response word
    function automatic ale_pkg::t_rsp list_apply(ale_pkg::t_req req);
        ale_pkg::t_rsp r;
        int unsigned   i;
        int unsigned   pos;
        r   = '0;
        pos = req.position;
        case (req.func)
            ale_pkg::F_APPEND: begin
                if (list_fill >= LIST_DEPTH) begin
                    r.status = ale_pkg::ST_FULL;
                end else begin
                    list_words[list_fill] = req.value;
                    list_fill++;
                end
            end
            ale_pkg::F_POP: begin
                if (list_fill == 0) r.status = ale_pkg::ST_EMPTY;
                else list_fill--;
            end
            ale_pkg::F_READ: begin
                if (pos >= list_fill) r.status = ale_pkg::ST_BADPOS;
                else r.data = list_words[pos];
            end
            ale_pkg::F_FIND: begin
                r.status = ale_pkg::ST_NOTFOUND;
                for (i = 0; i < list_fill; i++) begin
                    if (list_words[i] == req.value) begin
                        r.status   = ale_pkg::ST_OK;
                        r.found_at = 6'(i);
                        break;
                    end
                end
            end
            ale_pkg::F_INSERT: begin
                if (list_fill >= LIST_DEPTH) begin
                    r.status = ale_pkg::ST_FULL;
                end else if (pos > list_fill) begin
                    r.status = ale_pkg::ST_BADPOS;
                end else begin
                    for (i = list_fill; i > pos; i--) list_words[i] = list_words[i - 1];
                    list_words[pos] = req.value;
                    list_fill++;
                end
            end
            ale_pkg::F_DELETE: begin
                if (pos >= list_fill) begin
                    r.status = ale_pkg::ST_BADPOS;
                end else begin
                    for (i = pos; i + 1 < list_fill; i++) list_words[i] = list_words[i + 1];
                    list_fill--;
                end
            end
            default: ;
        endcase
        r.fill_count = 7'(list_fill);
        r.is_empty   = (list_fill == 0);
        return r;
    endfunction

    function automatic ale_pkg::t_req gen_request(t_mix mode);
        ale_pkg::t_req req;
        int unsigned   cut [6];
        int unsigned   pick;
        int unsigned   vpick;
        int unsigned   ppick;
        int unsigned   p;
        case (mode)
            MODE_GROW:   cut = '{40, 70, 80, 90, 95, 98};
            MODE_SHRINK: cut = '{5, 8, 18, 28, 63, 98};
            default:     cut = '{18, 36, 52, 68, 83, 98};
        endcase
        pick = $urandom_range(0, 99);
        if (pick < cut[0]) req.func = ale_pkg::F_APPEND;
        else if (pick < cut[1]) req.func = ale_pkg::F_INSERT;
        else if (pick < cut[2]) req.func = ale_pkg::F_READ;
        else if (pick < cut[3]) req.func = ale_pkg::F_FIND;
        else if (pick < cut[4]) req.func = ale_pkg::F_DELETE;
        else if (pick < cut[5]) req.func = ale_pkg::F_POP;
        else req.func = $urandom_range(0, 1) ? FUNC_SPARE_7 : FUNC_SPARE_6;

        vpick = $urandom_range(0, 99);
        if (vpick < 30 && list_fill > 0) begin
            req.value = list_words[$urandom_range(0, list_fill - 1)];
        end else if (vpick < 50) begin
            req.value = $urandom_range(0, 7);
        end else if (vpick < 60) begin
            case ($urandom_range(0, 3))
                0: req.value = 32'h0000_0000;
                1: req.value = 32'hFFFF_FFFF;
                2: req.value = 32'h8000_0000;
                default: req.value = 32'h7FFF_FFFF;
            endcase
        end else begin
            req.value = $urandom;
        end

        ppick = $urandom_range(0, 99);
        if (ppick < 70) begin
            if (req.func == ale_pkg::F_INSERT) p = $urandom_range(0, list_fill);
            else if (list_fill > 0) p = $urandom_range(0, list_fill - 1);
            else p = 0;
        end else if (ppick < 80) begin
            p = list_fill + $urandom_range(0, 1);
            if (p > LIST_DEPTH) p = LIST_DEPTH;
        end else if (ppick < 90) begin
            p = $urandom_range(0, 1) ? LIST_DEPTH : 0;
        end else begin
            p = $urandom_range(0, LIST_DEPTH);
        end
        req.position = 7'(p);
        return req;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < PRINT_CAP)
            $display("response %0d: %s got 0x%0h expected 0x%0h", rsp_seen, what, got, want);
        mismatches++;
    endtask

    task automatic send_word(ale_pkg::t_req req, bit typed, ale_pkg::t_rsp typed_rsp);
        ale_pkg::t_rsp predicted;
        req_if.valid   <= 1'b1;
        req_if.payload <= req;
        do @(posedge i_clk); while (!req_if.ready);
        predicted = list_apply(req);
        expected_rsp.push_back(typed ? typed_rsp : predicted);
        req_accepted++;
        op_tally[req.func]++;
        status_tally[predicted.status]++;
        if (list_fill > peak_fill) peak_fill = list_fill;
    endtask

    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, expected_rsp.size());
            $display("array_list_engine verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got_rsp = rsp_if.payload;
            if (expected_rsp.size() == 0) begin
                report_mismatch("unexpected word", 32'(got_rsp.status), 32'hFFFF_FFFF);
            end else begin
                want_rsp = expected_rsp.pop_front();
                if (got_rsp.status !== want_rsp.status)
                    report_mismatch("status", 32'(got_rsp.status), 32'(want_rsp.status));
                if (got_rsp.data !== want_rsp.data)
                    report_mismatch("data", got_rsp.data, want_rsp.data);
                if (got_rsp.found_at !== want_rsp.found_at)
                    report_mismatch("found_at", 32'(got_rsp.found_at), 32'(want_rsp.found_at));
                if (got_rsp.fill_count !== want_rsp.fill_count)
                    report_mismatch("fill_count", 32'(got_rsp.fill_count),
                                    32'(want_rsp.fill_count));
                if (got_rsp.is_empty !== want_rsp.is_empty)
                    report_mismatch("is_empty", 32'(got_rsp.is_empty), 32'(want_rsp.is_empty));
            end
            rsp_seen++;
        end
    end

    // receiver: changing stall styles, plus one long hold-off
    initial begin
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_left == 0) begin
                rx_style = t_rx_style'($urandom_range(0, 4));
                rx_left  = $urandom_range(50, 200);
            end
            rx_left--;
            if (!held_off && req_accepted >= HOLD_AT) begin
                held_off = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                case (rx_style)
                    RX_OPEN:     rsp_if.ready <= 1'b1;
                    RX_COIN:     rsp_if.ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY:   rsp_if.ready <= ($urandom_range(0, 99) < 85);
                    RX_PERIODIC: rsp_if.ready <= ((rx_left % 5) != 0);
                    default: begin
                        if ($urandom_range(0, 15) == 0) begin
                            rsp_if.ready <= 1'b0;
                            repeat ($urandom_range(2, 20)) @(posedge i_clk);
                        end else begin
                            rsp_if.ready <= 1'b1;
                        end
                    end
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin
        ale_pkg::t_req req;
        t_mix          gen_mode;
        int unsigned   seg_left;
        int unsigned   rnd_count;
        int            row;
        int            rep;

        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        list_fill = 0;
        seg_left  = 0;
        rnd_count = 0;
        gen_mode  = MODE_MIX;
        foreach (op_tally[k]) op_tally[k] = 0;
        foreach (status_tally[k]) status_tally[k] = 0;

        dir_rows[0]  = '{ale_pkg::F_POP, 32'h0, 7'd0, 1, 1'b1,
                         '{ale_pkg::ST_EMPTY, 32'h0, 6'd0, 7'd0, 1'b1}};
        dir_rows[1]  = '{ale_pkg::F_READ, 32'h0, 7'd0, 1, 1'b1,
                         '{ale_pkg::ST_BADPOS, 32'h0, 6'd0, 7'd0, 1'b1}};
        dir_rows[2]  = '{ale_pkg::F_DELETE, 32'h0, 7'd0, 1, 1'b1,
                         '{ale_pkg::ST_BADPOS, 32'h0, 6'd0, 7'd0, 1'b1}};
        dir_rows[3]  = '{ale_pkg::F_FIND, 32'h0, 7'd0, 1, 1'b1,
                         '{ale_pkg::ST_NOTFOUND, 32'h0, 6'd0, 7'd0, 1'b1}};
        dir_rows[4]  = '{ale_pkg::F_INSERT, 32'h1, 7'd1, 1, 1'b1,
                         '{ale_pkg::ST_BADPOS, 32'h0, 6'd0, 7'd0, 1'b1}};
        dir_rows[5]  = '{FUNC_SPARE_6, 32'h0, 7'd0, 1, 1'b1,
                         '{ale_pkg::ST_OK, 32'h0, 6'd0, 7'd0, 1'b1}};
        dir_rows[6]  = '{FUNC_SPARE_7, 32'hFFFF_FFFF, 7'd64, 1, 1'b1,
                         '{ale_pkg::ST_OK, 32'h0, 6'd0, 7'd0, 1'b1}};
        dir_rows[7]  = '{ale_pkg::F_INSERT, 32'hFFFF_FFFF, 7'd0, 1, 1'b1,
                         '{ale_pkg::ST_OK, 32'h0, 6'd0, 7'd1, 1'b0}};
        dir_rows[8]  = '{ale_pkg::F_APPEND, 32'h0, 7'd0, 1, 1'b1,
                         '{ale_pkg::ST_OK, 32'h0, 6'd0, 7'd2, 1'b0}};
        dir_rows[9]  = '{ale_pkg::F_READ, 32'h0, 7'd0, 1, 1'b1,
                         '{ale_pkg::ST_OK, 32'hFFFF_FFFF, 6'd0, 7'd2, 1'b0}};
        dir_rows[10] = '{ale_pkg::F_READ, 32'h0, 7'd1, 1, 1'b1,
                         '{ale_pkg::ST_OK, 32'h0, 6'd0, 7'd2, 1'b0}};
        dir_rows[11] = '{ale_pkg::F_FIND, 32'hFFFF_FFFF, 7'd0, 1, 1'b1,
                         '{ale_pkg::ST_OK, 32'h0, 6'd0, 7'd2, 1'b0}};
        dir_rows[12] = '{ale_pkg::F_FIND, 32'h0, 7'd0, 1, 1'b1,
                         '{ale_pkg::ST_OK, 32'h0, 6'd1, 7'd2, 1'b0}};
        dir_rows[13] = '{ale_pkg::F_READ, 32'h0, 7'd2, 1, 1'b1,
                         '{ale_pkg::ST_BADPOS, 32'h0, 6'd0, 7'd2, 1'b0}};
        dir_rows[14] = '{ale_pkg::F_APPEND, 32'h1000_0000, 7'd0, 62, 1'b0, '0};
        dir_rows[15] = '{ale_pkg::F_APPEND, 32'hA5A5_A5A5, 7'd0, 1, 1'b1,
                         '{ale_pkg::ST_FULL, 32'h0, 6'd0, 7'd64, 1'b0}};
        dir_rows[16] = '{ale_pkg::F_INSERT, 32'hA5A5_A5A5, 7'd0, 1, 1'b1,
                         '{ale_pkg::ST_FULL, 32'h0, 6'd0, 7'd64, 1'b0}};
        dir_rows[17] = '{ale_pkg::F_INSERT, 32'hA5A5_A5A5, 7'd64, 1, 1'b1,
                         '{ale_pkg::ST_FULL, 32'h0, 6'd0, 7'd64, 1'b0}};
        dir_rows[18] = '{ale_pkg::F_READ, 32'h0, 7'd63, 1, 1'b1,
                         '{ale_pkg::ST_OK, 32'h1000_003D, 6'd0, 7'd64, 1'b0}};
        dir_rows[19] = '{ale_pkg::F_READ, 32'h0, 7'd64, 1, 1'b1,
                         '{ale_pkg::ST_BADPOS, 32'h0, 6'd0, 7'd64, 1'b0}};
        dir_rows[20] = '{ale_pkg::F_FIND, 32'h1000_003D, 7'd0, 1, 1'b1,
                         '{ale_pkg::ST_OK, 32'h0, 6'd63, 7'd64, 1'b0}};
        dir_rows[21] = '{ale_pkg::F_FIND, 32'hDEAD_BEEF, 7'd0, 1, 1'b1,
                         '{ale_pkg::ST_NOTFOUND, 32'h0, 6'd0, 7'd64, 1'b0}};
        dir_rows[22] = '{ale_pkg::F_DELETE, 32'h0, 7'd64, 1, 1'b1,
                         '{ale_pkg::ST_BADPOS, 32'h0, 6'd0, 7'd64, 1'b0}};
        dir_rows[23] = '{ale_pkg::F_DELETE, 32'h0, 7'd0, 1, 1'b1,
                         '{ale_pkg::ST_OK, 32'h0, 6'd0, 7'd63, 1'b0}};
        dir_rows[24] = '{ale_pkg::F_DELETE, 32'h0, 7'd62, 1, 1'b1,
                         '{ale_pkg::ST_OK, 32'h0, 6'd0, 7'd62, 1'b0}};
        dir_rows[25] = '{ale_pkg::F_INSERT, 32'h5A5A_5A5A, 7'd62, 1, 1'b0, '0};
        dir_rows[26] = '{ale_pkg::F_INSERT, 32'h1234_5678, 7'd30, 1, 1'b0, '0};
        dir_rows[27] = '{ale_pkg::F_DELETE, 32'h0, 7'd20, 1, 1'b0, '0};
        dir_rows[28] = '{ale_pkg::F_FIND, 32'h1234_5678, 7'd0, 1, 1'b0, '0};
        dir_rows[29] = '{ale_pkg::F_POP, 32'h0, 7'd0, 64, 1'b0, '0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < DIR_ROWS; row++) begin
            for (rep = 0; rep < dir_rows[row].reps; rep++) begin
                req.func     = dir_rows[row].func;
                req.value    = dir_rows[row].value + 32'(rep);
                req.position = dir_rows[row].position;
                send_word(req, dir_rows[row].typed, dir_rows[row].rsp);
                pace_sender();
            end
        end

        while (rnd_count < RANDOM_ITEMS) begin
            if (seg_left == 0) begin
                gen_mode = t_mix'($urandom_range(0, 2));
                seg_left = $urandom_range(20, 90);
            end
            seg_left--;
            req = gen_request(gen_mode);
            send_word(req, 1'b0, '0);
            pace_sender();
            if (req.func <= 3'(ale_pkg::F_DELETE)) rnd_count++;
        end

        req_if.valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests: %0d append, %0d pop, %0d read, %0d find, %0d insert,",
                 req_accepted, op_tally[ale_pkg::F_APPEND], op_tally[ale_pkg::F_POP],
                 op_tally[ale_pkg::F_READ], op_tally[ale_pkg::F_FIND],
                 op_tally[ale_pkg::F_INSERT]);
        $display("%0d delete, %0d spare; %0d full, %0d empty, %0d bad position, %0d not found; peak fill %0d",
                 op_tally[ale_pkg::F_DELETE], op_tally[FUNC_SPARE_6] + op_tally[FUNC_SPARE_7],
                 status_tally[ale_pkg::ST_FULL], status_tally[ale_pkg::ST_EMPTY],
                 status_tally[ale_pkg::ST_BADPOS], status_tally[ale_pkg::ST_NOTFOUND],
                 peak_fill);
        if (mismatches == 0) begin
            $display("array_list_engine verification clean");
        end else begin
            $display("array_list_engine verification failed");
        end
        $finish;
    end

endmodule
